>>> design/rope_pkg.sv
package rope_pkg;

    // Field widths and table size
    localparam int PAIRS       = 32;
    localparam int IDX_W       = 5;
    localparam int POS_W       = 16;
    localparam int ELEM_W      = 16;
    localparam int FREQ_W      = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_W      = SAMPLE_BITS - 2;

    // Coefficient range
    localparam int COEF_MAX = 32767;

    // CORDIC datapath: x/y carry FRAC bits below the coefficient LSB,
    // z is a binary angle with TURN_W fraction bits of a turn.
    localparam int ITER    = 44;
    localparam int SHIFT_W = 6;
    localparam int FRAC    = 34;
    localparam int XW      = 51;
    localparam int TURN_W  = 60;
    localparam int ZW      = 62;

    localparam real PI = 3.14159265358979323846;

    // Binary-angle units per radian
    localparam real TURN_PER_RAD = (2.0 ** TURN_W) / (2.0 * PI);

    typedef enum logic {
        KIND_LOAD   = 1'b0,
        KIND_ROTATE = 1'b1
    } t_kind;

    typedef struct packed {
        logic                     vld;
        logic [1:0]               quad;
        logic [IDX_W-1:0]         idx;
        logic signed [ELEM_W-1:0] x0;
        logic signed [ELEM_W-1:0] x1;
        logic signed [XW-1:0]     x;
        logic signed [XW-1:0]     y;
        logic signed [ZW-1:0]     z;
    } t_cell;

    // atan(2^-stage) as a binary angle, evaluated at elaboration
    function automatic logic signed [ZW-1:0] atan_turn(input int stage);
        real a;
        a = $atan(2.0 ** (-stage)) * TURN_PER_RAD;
        return ZW'(longint'(a));
    endfunction

    // Start vector length, pre-scaled by the inverse CORDIC gain
    function automatic logic signed [XW-1:0] gain_init();
        real k;
        k = 1.0;
        for (int i = 0; i < ITER; i++) begin
            k = k * ((1.0 + 2.0 ** (-2 * i)) ** (-0.5));
        end
        return XW'(longint'(32767.0 * k * (2.0 ** FRAC)));
    endfunction

    localparam logic signed [XW-1:0] X_INIT = gain_init();

endpackage

>>> design/rope_cell.sv
module rope_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic [rope_pkg::SHIFT_W-1:0]       i_shift,
    input  logic signed [rope_pkg::ZW-1:0]     i_angle,
    input  rope_pkg::t_cell                    i_cell,
    output rope_pkg::t_cell                    o_cell
);

    logic                              r_vld;
    rope_pkg::t_cell                   r_cell;
    rope_pkg::t_cell                   n_cell;
    logic signed [rope_pkg::XW-1:0]    xs;
    logic signed [rope_pkg::XW-1:0]    ys;
    logic                              dir;

    // One micro-rotation: turn toward zero residual angle
    always_comb begin
        xs  = i_cell.x >>> i_shift;
        ys  = i_cell.y >>> i_shift;
        dir = ~i_cell.z[rope_pkg::ZW-1];
        n_cell = i_cell;
        if (dir) begin
            n_cell.x = i_cell.x - ys;
            n_cell.y = i_cell.y + xs;
            n_cell.z = i_cell.z - i_angle;
        end else begin
            n_cell.x = i_cell.x + ys;
            n_cell.y = i_cell.y - xs;
            n_cell.z = i_cell.z + i_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_cell.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    always_comb begin
        o_cell     = r_cell;
        o_cell.vld = r_vld;
    end

endmodule

>>> design/rope_mix.sv
module rope_mix (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  rope_pkg::t_cell                      i_cell,
    output logic                                 o_vld,
    output logic signed [rope_pkg::ELEM_W-1:0]   o_first,
    output logic signed [rope_pkg::ELEM_W-1:0]   o_second,
    output logic [rope_pkg::IDX_W-1:0]           o_pair
);

    localparam int PW = 2 * rope_pkg::ELEM_W;

    // Round a non-negative scaled value to a coefficient, half away from zero
    function automatic logic signed [rope_pkg::ELEM_W-1:0] coef_round(
        input logic signed [rope_pkg::XW-1:0] v
    );
        logic [rope_pkg::XW:0]              sum_r;
        logic [rope_pkg::XW-rope_pkg::FRAC:0] t;
        sum_r = {1'b0, v} + ((rope_pkg::XW+1)'(1) << (rope_pkg::FRAC - 1));
        t     = sum_r[rope_pkg::XW:rope_pkg::FRAC];
        if (v[rope_pkg::XW-1]) begin
            return '0;
        end else if (t > (rope_pkg::XW-rope_pkg::FRAC+1)'(rope_pkg::COEF_MAX)) begin
            return rope_pkg::ELEM_W'(rope_pkg::COEF_MAX);
        end else begin
            return t[rope_pkg::ELEM_W-1:0];
        end
    endfunction

    // Divide by 32768 rounding half away from zero, then saturate
    function automatic logic signed [rope_pkg::ELEM_W-1:0] scale_sat(
        input logic signed [PW:0] v
    );
        logic          neg;
        logic [PW:0]   mag;
        logic [PW+1:0] sum_r;
        logic [PW-14:0] m;
        neg   = v[PW];
        mag   = neg ? (PW+1)'(-v) : v;
        sum_r = {1'b0, mag} + (PW+2)'(16384);
        m     = sum_r[PW+1:15];
        if (neg) begin
            if (m >= (PW-13)'(32768)) begin
                return {1'b1, {(rope_pkg::ELEM_W-1){1'b0}}};
            end else begin
                return rope_pkg::ELEM_W'(-m);
            end
        end else begin
            if (m >= (PW-13)'(32767)) begin
                return {1'b0, {(rope_pkg::ELEM_W-1){1'b1}}};
            end else begin
                return m[rope_pkg::ELEM_W-1:0];
            end
        end
    endfunction

    logic signed [rope_pkg::ELEM_W-1:0] sn;
    logic signed [rope_pkg::ELEM_W-1:0] cs;
    logic signed [rope_pkg::ELEM_W-1:0] n_s;
    logic signed [rope_pkg::ELEM_W-1:0] n_c;

    logic                               r_m1_vld;
    logic signed [rope_pkg::ELEM_W-1:0] r_m1_s;
    logic signed [rope_pkg::ELEM_W-1:0] r_m1_c;
    logic signed [rope_pkg::ELEM_W-1:0] r_m1_x0;
    logic signed [rope_pkg::ELEM_W-1:0] r_m1_x1;
    logic [rope_pkg::IDX_W-1:0]         r_m1_idx;

    logic                               r_m2_vld;
    logic signed [PW-1:0]               r_m2_x0c;
    logic signed [PW-1:0]               r_m2_x1s;
    logic signed [PW-1:0]               r_m2_x0s;
    logic signed [PW-1:0]               r_m2_x1c;
    logic [rope_pkg::IDX_W-1:0]         r_m2_idx;

    // Fold the first-quadrant pair out to the full circle
    always_comb begin
        sn = coef_round(i_cell.y);
        cs = coef_round(i_cell.x);
        unique case (i_cell.quad)
            2'd0: begin n_s = sn;  n_c = cs;  end
            2'd1: begin n_s = cs;  n_c = -sn; end
            2'd2: begin n_s = -sn; n_c = -cs; end
            2'd3: begin n_s = -cs; n_c = sn;  end
            default: begin n_s = sn; n_c = cs; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
        end else if (i_en) begin
            r_m1_vld <= i_cell.vld;
            r_m2_vld <= r_m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1_s   <= n_s;
            r_m1_c   <= n_c;
            r_m1_x0  <= i_cell.x0;
            r_m1_x1  <= i_cell.x1;
            r_m1_idx <= i_cell.idx;
            r_m2_x0c <= r_m1_x0 * r_m1_c;
            r_m2_x1s <= r_m1_x1 * r_m1_s;
            r_m2_x0s <= r_m1_x0 * r_m1_s;
            r_m2_x1c <= r_m1_x1 * r_m1_c;
            r_m2_idx <= r_m1_idx;
        end
    end

    assign o_vld    = r_m2_vld;
    assign o_first  = scale_sat((PW+1)'(r_m2_x0c) - (PW+1)'(r_m2_x1s));
    assign o_second = scale_sat((PW+1)'(r_m2_x0s) + (PW+1)'(r_m2_x1c));
    assign o_pair   = r_m2_idx;

endmodule

>>> design/rotary_position_embedding_unit.sv
// Rotary position embedding, one element pair per request.
// Pipeline: a rotate result passes 49 stages (table read, phase multiply, 44
// CORDIC cells, coefficient, products, output register); one request per cycle
// while the skid slot is free; load requests produce no result.
// Reset (i_rst_n low, synchronous) empties the pipeline and output stage;
// frequency table contents stay undefined until loaded.
module rotary_position_embedding_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_kind,
    input  logic [rope_pkg::IDX_W-1:0]           i_pair_index,
    input  logic [rope_pkg::POS_W-1:0]           i_position,
    input  logic signed [rope_pkg::ELEM_W-1:0]   i_first_elem,
    input  logic signed [rope_pkg::ELEM_W-1:0]   i_second_elem,
    input  logic [rope_pkg::FREQ_W-1:0]          i_freq_word,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [rope_pkg::ELEM_W-1:0]   o_first_rot,
    output logic signed [rope_pkg::ELEM_W-1:0]   o_second_rot,
    output logic [rope_pkg::IDX_W-1:0]           o_pair_out
);

    localparam int PROD_W = rope_pkg::FREQ_W + rope_pkg::POS_W;

    // Frequency table: one word per pair, written by load requests
    logic [rope_pkg::FREQ_W-1:0] r_freq_tab [rope_pkg::PAIRS];

    // Pipeline advance: the whole chain moves while the skid slot is free
    logic adv;
    logic acc;

    // Stage 1: table read result
    logic                               r_p1_vld;
    logic [rope_pkg::FREQ_W-1:0]        r_p1_word;
    logic [rope_pkg::POS_W-1:0]         r_p1_pos;
    logic signed [rope_pkg::ELEM_W-1:0] r_p1_x0;
    logic signed [rope_pkg::ELEM_W-1:0] r_p1_x1;
    logic [rope_pkg::IDX_W-1:0]         r_p1_idx;

    // Stage 2: phase sample
    logic                               r_p2_vld;
    logic [rope_pkg::SAMPLE_BITS-1:0]   r_p2_phase;
    logic signed [rope_pkg::ELEM_W-1:0] r_p2_x0;
    logic signed [rope_pkg::ELEM_W-1:0] r_p2_x1;
    logic [rope_pkg::IDX_W-1:0]         r_p2_idx;
    logic [PROD_W-1:0]                  phase_prod;

    rope_pkg::t_cell chain [rope_pkg::ITER+1];

    // Result from the coefficient/product stages
    logic                               mix_vld;
    logic signed [rope_pkg::ELEM_W-1:0] mix_first;
    logic signed [rope_pkg::ELEM_W-1:0] mix_second;
    logic [rope_pkg::IDX_W-1:0]         mix_pair;

    // Output register and skid slot
    logic                               r_out_vld;
    logic signed [rope_pkg::ELEM_W-1:0] r_out_first;
    logic signed [rope_pkg::ELEM_W-1:0] r_out_second;
    logic [rope_pkg::IDX_W-1:0]         r_out_pair;
    logic                               r_skid_vld;
    logic signed [rope_pkg::ELEM_W-1:0] r_skid_first;
    logic signed [rope_pkg::ELEM_W-1:0] r_skid_second;
    logic [rope_pkg::IDX_W-1:0]         r_skid_pair;
    logic                               take;

    assign adv     = ~r_skid_vld;
    assign o_ready = adv;
    assign acc     = i_valid & o_ready;
    assign take    = r_out_vld & i_ready;

    // Load requests write the table at acceptance; a rotate accepted in
    // the next cycle already sees the new word.
    always_ff @(posedge i_clk) begin
        if (acc && (i_kind == rope_pkg::KIND_LOAD)) begin
            r_freq_tab[i_pair_index] <= i_freq_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else if (adv) begin
            r_p1_vld <= acc && (i_kind == rope_pkg::KIND_ROTATE);
            r_p2_vld <= r_p1_vld;
        end
    end

    assign phase_prod = PROD_W'(r_p1_word) * PROD_W'(r_p1_pos);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_word  <= r_freq_tab[i_pair_index];
            r_p1_pos   <= i_position;
            r_p1_x0    <= i_first_elem;
            r_p1_x1    <= i_second_elem;
            r_p1_idx   <= i_pair_index;
            // keep only the top sample bits of the phase, modulo one turn
            r_p2_phase <= phase_prod[rope_pkg::FREQ_W-1 -: rope_pkg::SAMPLE_BITS];
            r_p2_x0    <= r_p1_x0;
            r_p2_x1    <= r_p1_x1;
            r_p2_idx   <= r_p1_idx;
        end
    end

    // Seed the chain: quadrant rides along, the remaining fraction of a
    // quarter turn becomes the start angle, start vector on the x axis.
    always_comb begin
        chain[0].vld  = r_p2_vld;
        chain[0].quad = r_p2_phase[rope_pkg::SAMPLE_BITS-1 -: 2];
        chain[0].idx  = r_p2_idx;
        chain[0].x0   = r_p2_x0;
        chain[0].x1   = r_p2_x1;
        chain[0].x    = rope_pkg::X_INIT;
        chain[0].y    = '0;
        chain[0].z    = rope_pkg::ZW'(r_p2_phase[rope_pkg::FRAC_W-1:0])
                        << (rope_pkg::TURN_W - rope_pkg::SAMPLE_BITS);
    end

    genvar g;
    generate
        for (g = 0; g < rope_pkg::ITER; g++) begin : g_cell
            rope_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (adv),
                .i_shift (rope_pkg::SHIFT_W'(g)),
                .i_angle (rope_pkg::atan_turn(g)),
                .i_cell  (chain[g]),
                .o_cell  (chain[g+1])
            );
        end
    endgenerate

    rope_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_cell   (chain[rope_pkg::ITER]),
        .o_vld    (mix_vld),
        .o_first  (mix_first),
        .o_second (mix_second),
        .o_pair   (mix_pair)
    );

    // Output stage: hold the result until taken; park one more in the
    // skid slot, which stops the pipeline until it drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || take) begin
            r_out_vld <= mix_vld;
        end else if (mix_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (take) begin
                r_out_first  <= r_skid_first;
                r_out_second <= r_skid_second;
                r_out_pair   <= r_skid_pair;
            end
        end else if (!r_out_vld || take) begin
            r_out_first  <= mix_first;
            r_out_second <= mix_second;
            r_out_pair   <= mix_pair;
        end else begin
            r_skid_first  <= mix_first;
            r_skid_second <= mix_second;
            r_skid_pair   <= mix_pair;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_first_rot  = r_out_first;
    assign o_second_rot = r_out_second;
    assign o_pair_out   = r_out_pair;

endmodule

>>> design/rope_chk.sv
module rope_chk (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 o_ready,
    input  logic                                 o_valid,
    input  logic                                 i_ready,
    input  logic signed [rope_pkg::ELEM_W-1:0]   o_first_rot,
    input  logic signed [rope_pkg::ELEM_W-1:0]   o_second_rot,
    input  logic [rope_pkg::IDX_W-1:0]           o_pair_out
);

    // Reset leaves the output empty and the input side open
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("output not cleared by reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_first_rot)
                                   && $stable(o_second_rot) && $stable(o_pair_out)))
        else $error("stalled result changed");

    // Back-pressure only with a result waiting at the output
    a_busy_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input blocked with no result pending");

    // Input side closes only after an output stall
    a_close_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_ready) |-> $past(o_valid && !i_ready))
        else $error("input closed without output stall");

endmodule

bind rotary_position_embedding_unit rope_chk u_rope_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_first_rot  (o_first_rot),
    .o_second_rot (o_second_rot),
    .o_pair_out   (o_pair_out)
);
